### rtl/lsp_pkg.sv
// Shared types and constants for the LIFO stack with peek.
package lsp_pkg;

  // Fixed field widths
  localparam int unsigned DataW   = 32;
  localparam int unsigned OpW     = 2;
  localparam int unsigned PosW    = 7;
  localparam int unsigned LimitW  = 7;
  localparam int unsigned CountW  = 7;
  localparam int unsigned StatusW = 2;

  // Defaults
  localparam int unsigned          DefMaxDepth = 64;
  localparam logic [LimitW-1:0]    LimitRst    = 7'd64;
  localparam logic [DataW-1:0]     FailWord    = '1;

  // Operation codes
  typedef enum logic [OpW-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2
  } op_e;

  // Status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_BADPOS    = 2'd3
  } status_e;

  // Per-cycle control broadcast to every cell
  typedef struct packed {
    logic push;   // take word from the cell above (toward the top)
    logic pop;    // take word from the cell below
    logic load;   // snapshot own word into the scan register
    logic shift;  // move scan word one cell toward the top
  } cell_ctrl_t;

  // One result item
  typedef struct packed {
    logic [CountW-1:0] count;
    logic              full;
    logic              empty;
    status_e           status;
    logic [DataW-1:0]  data;
  } res_t;

endpackage

### rtl/lifo_stack_with_peek_core.sv
// Top level: LIFO stack built from a chain of cells, with control and result register.
// Push, pop, failed ops and unused op codes: result registered in the cycle after the input transfer;
// the next item is taken in the following cycle unless the output is stalled (one item per cycle).
// Peek at position p: p-1 shifts of the scan chain plus one load, then the result is registered;
// no new item is taken during the scan.
// Reset clears the entry count and sets the limit to 64; cell contents are not cleared.
module lifo_stack_with_peek_core
  import lsp_pkg::*;
#(
  parameter int unsigned MAX_DEPTH = DefMaxDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config write
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [LimitW-1:0]   cfg_data_i,     // stack_limit
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [39:0]         s_axis_tdata,   // [31:0] value, [38:32] peek_pos
  input  logic [OpW-1:0]      s_axis_tuser,   // [1:0] op
  // output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [47:0]         m_axis_tdata,   // [31:0] data, [32] is_empty, [33] is_full,
                                              // [40:34] count
  output logic [StatusW-1:0]  m_axis_tuser    // [1:0] status
);

  localparam int unsigned CntW  = $clog2(MAX_DEPTH + 1);
  localparam int unsigned CmpW  = (CntW > PosW) ? CntW : PosW;
  localparam int unsigned ScanW = $clog2(MAX_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [LimitW-1:0] limit_q;
  logic [ScanW-1:0]  scan_cnt_q, scan_cnt_d;
  logic              out_valid_q, out_valid_d;
  res_t              out_res_q, res_d;
  logic              res_load;
  cell_ctrl_t        ctrl;

  logic [DataW-1:0]  word_w [MAX_DEPTH];
  logic [DataW-1:0]  scan_w [MAX_DEPTH];

  // Input decode
  logic              in_fire;
  op_e               op;
  logic [DataW-1:0]  in_value;
  logic [PosW-1:0]   in_pos;

  assign in_value = s_axis_tdata[31:0];
  assign in_pos   = s_axis_tdata[38:32];
  assign op       = op_e'(s_axis_tuser);

  // Limit in effect and comparisons, all at a common width
  logic [CmpW-1:0] lim_ext, depth_ext, lim_eff, cnt_ext, pos_ext;
  logic            stack_full;

  assign lim_ext    = CmpW'(limit_q);
  assign depth_ext  = CmpW'(MAX_DEPTH);
  assign lim_eff    = (lim_ext > depth_ext) ? depth_ext : lim_ext;
  assign cnt_ext    = CmpW'(cnt_q);
  assign pos_ext    = CmpW'(in_pos);
  assign stack_full = (cnt_ext >= lim_eff);

  // Handshakes
  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Control: op decode, cell commands and result
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    scan_cnt_d = scan_cnt_q;
    ctrl       = '0;
    res_load   = 1'b0;
    res_d.data   = FailWord;
    res_d.status = ST_OK;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          res_load = 1'b1;
          case (op)
            OP_PUSH: begin
              if (stack_full) begin
                res_d.status = ST_OVERFLOW;
              end else begin
                ctrl.push  = 1'b1;
                cnt_d      = cnt_q + 1'b1;
                res_d.data = in_value;
              end
            end
            OP_POP: begin
              if (cnt_q == '0) begin
                res_d.status = ST_UNDERFLOW;
              end else begin
                ctrl.pop   = 1'b1;
                cnt_d      = cnt_q - 1'b1;
                res_d.data = word_w[0];
              end
            end
            OP_PEEK: begin
              if ((pos_ext == '0) || (pos_ext > cnt_ext)) begin
                res_d.status = ST_BADPOS;
              end else begin
                // walk the chosen entry up to the top cell
                res_load   = 1'b0;
                ctrl.load  = 1'b1;
                scan_cnt_d = ScanW'(pos_ext - 1'b1);
                state_d    = S_SCAN;
              end
            end
            default: begin
              res_d.status = ST_OK;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_cnt_q == '0) begin
          res_load   = 1'b1;
          res_d.data = scan_w[0];
          state_d    = S_IDLE;
        end else begin
          ctrl.shift = 1'b1;
          scan_cnt_d = scan_cnt_q - 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_d.empty = (cnt_d == '0);
    res_d.full  = (CmpW'(cnt_d) >= lim_eff);
    res_d.count = CountW'(cnt_d);
  end

  // Output register valid
  always_comb begin
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      scan_cnt_q  <= '0;
      limit_q     <= LimitRst;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      scan_cnt_q  <= scan_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_res_q.count, out_res_q.full, out_res_q.empty,
                          out_res_q.data};
  assign m_axis_tuser  = out_res_q.status;

  // Cell chain: cell 0 is the top of the stack
  for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
    logic [DataW-1:0] up_w, down_w, scan_down_w;

    if (i == 0) begin : g_top
      assign up_w = in_value;
    end else begin : g_mid
      assign up_w = word_w[i-1];
    end

    if (i == MAX_DEPTH - 1) begin : g_bot
      assign down_w      = '0;
      assign scan_down_w = '0;
    end else begin : g_inner
      assign down_w      = word_w[i+1];
      assign scan_down_w = scan_w[i+1];
    end

    lsp_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .word_up_i   (up_w),
      .word_down_i (down_w),
      .scan_down_i (scan_down_w),
      .word_o      (word_w[i]),
      .scan_o      (scan_w[i])
    );
  end

endmodule

### rtl/lsp_cell.sv
// One stack cell: holds one entry and one scan word, shifts with its neighbors.
module lsp_cell
  import lsp_pkg::*;
(
  input  logic             clk_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic [DataW-1:0] word_up_i,    // word of the cell nearer the top
  input  logic [DataW-1:0] word_down_i,  // word of the cell deeper in the stack
  input  logic [DataW-1:0] scan_down_i,  // scan word of the deeper cell
  output logic [DataW-1:0] word_o,
  output logic [DataW-1:0] scan_o
);

  logic [DataW-1:0] word_q, word_d;
  logic [DataW-1:0] scan_q, scan_d;

  // Entry: shift down on push, up on pop
  always_comb begin
    if (ctrl_i.push) begin
      word_d = word_up_i;
    end else if (ctrl_i.pop) begin
      word_d = word_down_i;
    end else begin
      word_d = word_q;
    end
  end

  // Scan word: snapshot, then walk toward the top
  always_comb begin
    if (ctrl_i.load) begin
      scan_d = word_q;
    end else if (ctrl_i.shift) begin
      scan_d = scan_down_i;
    end else begin
      scan_d = scan_q;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    scan_q <= scan_d;
  end

  assign word_o = word_q;
  assign scan_o = scan_q;

endmodule
